// ----- sv/mandelbrot_escape_time_unit_defines.svh -----
// Assertion macros for the escape-time unit.
// Used by met_ctrl and mandelbrot_escape_time_unit; expects clk and arst_n in scope.
`ifndef MANDELBROT_ESCAPE_TIME_UNIT_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_UNIT_DEFINES_SVH
`ifndef SYNTH
`define MET_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("assertion failed");
`define MET_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
	else $error("forbidden condition seen");
`else
`define MET_ASSERT(lbl, prop)
`define MET_ASSERT_NEVER(lbl, expr)
`endif
`endif

// ----- sv/met_pkg.sv -----
// Shared types and constants of the escape-time unit.
// No dependencies.
`timescale 1ns / 1ps

package met_pkg;

	localparam int FRAC_BITS = 28;
	localparam int COORD_W   = 32;
	localparam int IDX_W     = 12;
	localparam int CNT_W     = 12;
	localparam int PROD_W    = 2 * COORD_W;

	// escape threshold 4.0 at 2*FRAC_BITS fraction bits; off when not representable
	localparam bit              ESC_EN    = (2 * FRAC_BITS + 2) < 64;
	localparam logic [63:0]     ESC_LIMIT = ESC_EN ? (64'd1 << (2 * FRAC_BITS + 2)) : 64'd0;

	localparam logic signed [COORD_W-1:0] START_RE_RST = 32'shE0000000;
	localparam logic signed [COORD_W-1:0] START_IM_RST = 32'shF0000000;
	localparam logic signed [COORD_W-1:0] STEP_RE_RST  = 32'sd1610612;
	localparam logic signed [COORD_W-1:0] STEP_IM_RST  = 32'sd1073741;
	localparam logic [CNT_W-1:0]          MAX_ITER_RST = 12'd256;

	typedef enum logic [2:0] {
		REG_START_RE  = 3'd0,
		REG_START_IM  = 3'd1,
		REG_STEP_RE   = 3'd2,
		REG_STEP_IM   = 3'd3,
		REG_MAX_ITERS = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		MUL_COL_STEP,
		MUL_ROW_STEP,
		MUL_RE_RE,
		MUL_IM_IM,
		MUL_RE_IM
	} mul_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_C_RE,
		ST_C_IM,
		ST_SQ_RE,
		ST_SQ_IM,
		ST_CROSS,
		ST_UPDATE
	} state_t;

	// sequencer to datapath
	typedef struct packed {
		mul_sel_t mul_sel;
		logic     accept;
		logic     ld_c_re;
		logic     ld_c_im;
		logic     ld_rr;
		logic     ld_cross;
		logic     upd_z;
		logic     out_load;
	} ctl_t;

endpackage

// ----- sv/mandelbrot_escape_time_unit.sv -----
// Top level of the Mandelbrot escape-time unit: config registers, iterate datapath,
// result register. Depends on met_pkg, met_mul, met_ctrl and the defines header.
`timescale 1ns / 1ps
`include "mandelbrot_escape_time_unit_defines.svh"

// Usage
//  - Input beat: column and row of one pixel, taken when in_valid is high and
//    in_stall is low. in_stall is low only while the unit has no pixel in work.
//  - Output beat: escape_count, offered with out_valid until out_stall is low.
//  - Config: cfg_index/cfg_data written when cfg_valid and cfg_ready are high;
//    cfg_ready is always high. Indices above max_iters are dropped. Write only
//    while no pixel is in work or waiting at the output.
//  - One 32x32 multiplier is shared by everything. Forming c uses it for
//    column*step_re, then row*step_im; each iteration uses it for re^2,
//    im^2 and re*im, then updates z. The iteration loop through the
//    multiplier sets the pixel rate, and the unit takes the next pixel only
//    after the current one has left its update step.
//  - The result register lets a new pixel start while the previous result
//    waits. If the receiver still stalls when the next result is ready, the
//    unit holds in its update step until the register frees.
//  - Reset (arst_n low) loads the default view and limit 256 and empties the
//    unit; no beat is lost or repeated across a stall.
module mandelbrot_escape_time_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [met_pkg::IDX_W-1:0]          column,
	input  logic [met_pkg::IDX_W-1:0]          row,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [met_pkg::CNT_W-1:0]          escape_count,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [2:0]                         cfg_index,
	input  logic [met_pkg::COORD_W-1:0]        cfg_data
);

	localparam int F     = met_pkg::FRAC_BITS;
	localparam int CW    = met_pkg::COORD_W;
	localparam int PW    = met_pkg::PROD_W;
	localparam int WIDE  = PW + 2;     // rounding sums
	localparam int SUM_W = PW - F + 4; // floored real part before saturation

	localparam logic signed [PW-1:0] SAT_MAX = PW'(64'sh000000007FFFFFFF);
	localparam logic signed [PW-1:0] SAT_MIN = PW'(-64'sh0000000080000000);

	function automatic logic signed [CW-1:0] sat32(input logic signed [PW-1:0] v);
		logic signed [CW-1:0] r;
		if (v > SAT_MAX)
			r = SAT_MAX[CW-1:0];
		else if (v < SAT_MIN)
			r = SAT_MIN[CW-1:0];
		else
			r = $signed(v[CW-1:0]);
		return r;
	endfunction

	// configuration
	logic signed [CW-1:0]             start_re_q;
	logic signed [CW-1:0]             start_im_q;
	logic signed [CW-1:0]             step_re_q;
	logic signed [CW-1:0]             step_im_q;
	logic [met_pkg::CNT_W-1:0]        max_iters_q;

	// datapath
	logic [met_pkg::IDX_W-1:0]        column_q;
	logic [met_pkg::IDX_W-1:0]        row_q;
	logic signed [CW-1:0]             c_re_q;
	logic signed [CW-1:0]             c_im_q;
	logic signed [CW-1:0]             z_re_q;
	logic signed [CW-1:0]             z_im_q;
	logic signed [PW-1:0]             prod_q;
	logic signed [PW-1:0]             rr_q;
	logic signed [SUM_W-1:0]          re_sum_q;
	logic                             esc_q;
	logic                             out_valid_q;
	logic [met_pkg::CNT_W-1:0]        escape_count_q;

	met_pkg::ctl_t                    ctl;
	logic [met_pkg::CNT_W-1:0]        count;
	logic                             out_free;

	logic signed [PW-1:0]             c_sum;
	logic [PW:0]                      mag_sq;
	logic signed [WIDE-1:0]           re_wide;
	logic signed [WIDE-1:0]           re_shift;
	logic signed [WIDE-1:0]           im_wide;
	logic signed [WIDE-1:0]           im_shift;
	logic signed [CW-1:0]             z_re_nxt;
	logic signed [CW-1:0]             z_im_nxt;

	assign cfg_ready    = 1'b1;
	assign out_valid    = out_valid_q;
	assign escape_count = escape_count_q;
	assign out_free     = !out_valid_q || !out_stall;

	met_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.max_iters (max_iters_q),
		.esc       (esc_q),
		.out_free  (out_free),
		.ctl       (ctl),
		.count     (count)
	);

	met_mul u_mul (
		.clk     (clk),
		.sel     (ctl.mul_sel),
		.column  (column_q),
		.row     (row_q),
		.step_re (step_re_q),
		.step_im (step_im_q),
		.z_re    (z_re_q),
		.z_im    (z_im_q),
		.prod_q  (prod_q)
	);

	// c = start + index*step; prod_q holds index*step for the coordinate in turn
	assign c_sum = prod_q + (ctl.ld_c_re ? PW'(start_re_q) : PW'(start_im_q));

	// cross step: prod_q = im^2. Escape test on the exact sum; real part folded
	// with c and the rounding half so a single shift gives round-then-add.
	assign mag_sq   = {1'b0, rr_q} + {1'b0, prod_q};
	assign re_wide  = WIDE'(rr_q) - WIDE'(prod_q) + (WIDE'(c_re_q) <<< F)
		+ (WIDE'(1) <<< (F - 1));
	assign re_shift = re_wide >>> F;

	// update step: prod_q = re*im; doubling is one shift less
	assign im_wide  = WIDE'(prod_q) + (WIDE'(c_im_q) <<< (F - 1))
		+ (WIDE'(1) <<< (F - 2));
	assign im_shift = im_wide >>> (F - 1);

	assign z_re_nxt = sat32(PW'(re_sum_q));
	assign z_im_nxt = sat32($signed(im_shift[PW-1:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_re_q  <= met_pkg::START_RE_RST;
			start_im_q  <= met_pkg::START_IM_RST;
			step_re_q   <= met_pkg::STEP_RE_RST;
			step_im_q   <= met_pkg::STEP_IM_RST;
			max_iters_q <= met_pkg::MAX_ITER_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					met_pkg::REG_START_RE:  start_re_q  <= $signed(cfg_data);
					met_pkg::REG_START_IM:  start_im_q  <= $signed(cfg_data);
					met_pkg::REG_STEP_RE:   step_re_q   <= $signed(cfg_data);
					met_pkg::REG_STEP_IM:   step_im_q   <= $signed(cfg_data);
					met_pkg::REG_MAX_ITERS: max_iters_q <= cfg_data[met_pkg::CNT_W-1:0];
					default: ;
				endcase
			end
			if (ctl.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			column_q <= column;
			row_q    <= row;
		end
		if (ctl.ld_c_re) begin
			c_re_q <= sat32(c_sum);
			z_re_q <= sat32(c_sum);
		end
		if (ctl.ld_c_im) begin
			c_im_q <= sat32(c_sum);
			z_im_q <= sat32(c_sum);
		end
		if (ctl.ld_rr)
			rr_q <= prod_q;
		if (ctl.ld_cross) begin
			esc_q    <= met_pkg::ESC_EN && ({1'b0, met_pkg::ESC_LIMIT} < mag_sq);
			re_sum_q <= re_shift[SUM_W-1:0];
		end
		if (ctl.upd_z) begin
			z_re_q <= z_re_nxt;
			z_im_q <= z_im_nxt;
		end
		if (ctl.out_load)
			escape_count_q <= count;
	end

	`MET_ASSERT(a_count_in_limit, out_valid |-> (escape_count <= max_iters_q))
	`MET_ASSERT(a_no_update_when_loading, ctl.out_load |-> !ctl.upd_z)
	`MET_ASSERT(a_result_after_work, $rose(out_valid) |-> $past(in_stall))

endmodule

// ----- sv/met_mul.sv -----
// Shared 32x32 signed multiplier with operand select and registered product.
// Depends on met_pkg.
`timescale 1ns / 1ps

module met_mul (
	input  logic                               clk,
	input  met_pkg::mul_sel_t                  sel,
	input  logic [met_pkg::IDX_W-1:0]          column,
	input  logic [met_pkg::IDX_W-1:0]          row,
	input  logic signed [met_pkg::COORD_W-1:0] step_re,
	input  logic signed [met_pkg::COORD_W-1:0] step_im,
	input  logic signed [met_pkg::COORD_W-1:0] z_re,
	input  logic signed [met_pkg::COORD_W-1:0] z_im,
	output logic signed [met_pkg::PROD_W-1:0]  prod_q
);

	logic signed [met_pkg::COORD_W-1:0] op_a;
	logic signed [met_pkg::COORD_W-1:0] op_b;

	always_comb begin
		unique case (sel)
			met_pkg::MUL_COL_STEP: begin
				op_a = $signed({{(met_pkg::COORD_W - met_pkg::IDX_W){1'b0}}, column});
				op_b = step_re;
			end
			met_pkg::MUL_ROW_STEP: begin
				op_a = $signed({{(met_pkg::COORD_W - met_pkg::IDX_W){1'b0}}, row});
				op_b = step_im;
			end
			met_pkg::MUL_RE_RE: begin
				op_a = z_re;
				op_b = z_re;
			end
			met_pkg::MUL_IM_IM: begin
				op_a = z_im;
				op_b = z_im;
			end
			default: begin
				op_a = z_re;
				op_b = z_im;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= met_pkg::PROD_W'(op_a) * met_pkg::PROD_W'(op_b);
	end

endmodule

// ----- sv/met_ctrl.sv -----
// Sequencer of the escape-time unit: state machine, iteration counter, limit.
// Depends on met_pkg and mandelbrot_escape_time_unit_defines.svh.
`timescale 1ns / 1ps
`include "mandelbrot_escape_time_unit_defines.svh"

module met_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [met_pkg::CNT_W-1:0] max_iters,
	input  logic                      esc,
	input  logic                      out_free,
	output met_pkg::ctl_t             ctl,
	output logic [met_pkg::CNT_W-1:0] count
);

	met_pkg::state_t           state_q;
	met_pkg::state_t           state_nxt;
	logic [met_pkg::CNT_W-1:0] n_q;
	logic [met_pkg::CNT_W-1:0] limit_q;
	logic                      done;

	// limit reached or magnitude over four
	assign done     = esc || (n_q == limit_q);
	assign in_stall = (state_q != met_pkg::ST_IDLE);
	assign count    = n_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			met_pkg::ST_IDLE:   if (in_valid) state_nxt = met_pkg::ST_C_RE;
			met_pkg::ST_C_RE:   state_nxt = met_pkg::ST_C_IM;
			met_pkg::ST_C_IM:   state_nxt = met_pkg::ST_SQ_RE;
			met_pkg::ST_SQ_RE:  state_nxt = met_pkg::ST_SQ_IM;
			met_pkg::ST_SQ_IM:  state_nxt = met_pkg::ST_CROSS;
			met_pkg::ST_CROSS:  state_nxt = met_pkg::ST_UPDATE;
			met_pkg::ST_UPDATE: begin
				if (!done)
					state_nxt = met_pkg::ST_SQ_RE;
				else if (out_free)
					state_nxt = met_pkg::ST_IDLE;
			end
			default:            state_nxt = met_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		ctl.mul_sel = met_pkg::MUL_RE_IM;
		unique case (state_q)
			met_pkg::ST_IDLE: begin
				ctl.accept = in_valid;
			end
			met_pkg::ST_C_RE: begin
				ctl.mul_sel = met_pkg::MUL_COL_STEP;
			end
			met_pkg::ST_C_IM: begin
				ctl.mul_sel = met_pkg::MUL_ROW_STEP;
				ctl.ld_c_re = 1'b1;
			end
			met_pkg::ST_SQ_RE: begin
				ctl.mul_sel = met_pkg::MUL_RE_RE;
				ctl.ld_c_im = (n_q == '0);
			end
			met_pkg::ST_SQ_IM: begin
				ctl.mul_sel = met_pkg::MUL_IM_IM;
				ctl.ld_rr   = 1'b1;
			end
			met_pkg::ST_CROSS: begin
				ctl.mul_sel  = met_pkg::MUL_RE_IM;
				ctl.ld_cross = 1'b1;
			end
			met_pkg::ST_UPDATE: begin
				ctl.upd_z    = !done;
				ctl.out_load = done && out_free;
			end
			default: begin
				ctl.accept = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= met_pkg::ST_IDLE;
			n_q     <= '0;
			limit_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (ctl.accept) begin
				n_q     <= '0;
				limit_q <= max_iters;
			end else if (ctl.upd_z) begin
				n_q <= n_q + 1'b1;
			end
		end
	end

	`MET_ASSERT(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall)
	`MET_ASSERT(a_update_below_limit, ctl.upd_z |-> (n_q < limit_q))
	`MET_ASSERT(a_count_bounded, (state_q != met_pkg::ST_IDLE) |-> (n_q <= limit_q))
	`MET_ASSERT_NEVER(a_load_when_full, ctl.out_load && !out_free)

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for mandelbrot_escape_time_unit: directed corners, then random views.
// Needs met_pkg and the unit's RTL; escape counts are predicted in-bench, no files read.
`timescale 1ns / 1ps

module tb_top;
	import met_pkg::*;

	// knobs
	localparam int IDLE_PCT     = 28;        // idle/stall odds per cycle, percent
	localparam int HOLD_CYCLES  = 600;       // one long output stall to back the unit up
	localparam int RAND_PHASES  = 10;
	localparam int RAND_ITEMS   = 83;        // pixels per random phase
	localparam int HOLD_PHASE   = 1;
	localparam int STEADY_PHASE = 2;         // no idling on either side
	localparam int NOISE_PHASE  = 4;         // raw 32-bit view registers
	localparam int LONG_PHASE   = 6;         // deeper iteration limit
	localparam int TINY_PHASE   = 8;         // limit of zero to three
	localparam int CYCLE_LIMIT  = 3_000_000;

	// Q4.28 helpers
	localparam int          FRAC       = FRAC_BITS;
	localparam longint      Q_MAX      = 64'sh0000_0000_7FFF_FFFF;
	localparam longint      Q_MIN      = -64'sh0000_0000_8000_0000;
	localparam bit          CAN_ESCAPE = (2 * FRAC + 2) < 64;
	localparam longint unsigned MAG_FOUR =
		CAN_ESCAPE ? (64'd1 << ((2 * FRAC + 2) % 64)) : 64'd0;

	typedef struct packed {
		logic [IDX_W-1:0] column;
		logic [IDX_W-1:0] row;
	} pixel_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic [IDX_W-1:0]     column    = '0;
	logic [IDX_W-1:0]     row       = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [CNT_W-1:0]     escape_count;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [2:0]           cfg_index = '0;
	logic [COORD_W-1:0]   cfg_data  = '0;

	// bench copy of the view registers
	logic signed [COORD_W-1:0] view_start_re;
	logic signed [COORD_W-1:0] view_start_im;
	logic signed [COORD_W-1:0] view_step_re;
	logic signed [COORD_W-1:0] view_step_im;
	logic [CNT_W-1:0]          view_max_iters;

	pixel_t           pixel_q[$];    // pixels not yet taken by the unit
	logic [CNT_W-1:0] escape_q[$];   // predicted counts, oldest first

	int  mismatches = 0;
	int  cycles     = 0;
	bit  steady     = 1'b0;
	bit  hold_req   = 1'b0;
	bit  hold_done;
	int  hold_left;

	mandelbrot_escape_time_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.column       (column),
		.row          (row),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.escape_count (escape_count),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Escape-time predictor
	// ------------------------------------------------------------------

	function automatic longint clip_q(longint v);
		if (v > Q_MAX)
			return Q_MAX;
		if (v < Q_MIN)
			return Q_MIN;
		return v;
	endfunction

	// nearest, ties up: add half an LSB then floor via arithmetic shift
	function automatic longint round_q(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic logic [CNT_W-1:0] escape_iters(logic [IDX_W-1:0] col,
			logic [IDX_W-1:0] rw);
		longint            cr, ci, zr, zi, ri;
		longint unsigned   rr, ii;
		int unsigned       n;
		cr = clip_q(longint'(view_start_re) + longint'(col) * longint'(view_step_re));
		ci = clip_q(longint'(view_start_im) + longint'(rw) * longint'(view_step_im));
		// z starts at c, so the first test is on c itself
		zr = cr;
		zi = ci;
		n  = 0;
		while (n < view_max_iters) begin
			rr = zr * zr;
			ii = zi * zi;
			ri = zr * zi;
			// exact Q8.56 magnitude against 4.0, strictly greater escapes
			if (CAN_ESCAPE && (rr + ii > MAG_FOUR))
				break;
			// one less shift on re*im gives 2*re*im
			zr = clip_q(round_q(longint'(rr) - longint'(ii), FRAC) + cr);
			zi = clip_q(round_q(ri, FRAC - 1) + ci);
			n++;
		end
		return CNT_W'(n);
	endfunction

	// ------------------------------------------------------------------
	// Input driver: presents pixel_q[0] until the beat is taken
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin : pixel_driver
		bit took;
		if (!arst_n) begin
			in_valid <= 1'b0;
			column   <= '0;
			row      <= '0;
		end else begin
			took = in_valid && !in_stall;
			if (took) begin
				// config only moves while idle, so the view here is the one in use
				escape_q.push_back(escape_iters(column, row));
				void'(pixel_q.pop_front());
			end
			// a stalled beat holds; otherwise offer the next pixel or idle
			if (!in_valid || took) begin
				if (pixel_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
					in_valid <= 1'b1;
					column   <= pixel_q[0].column;
					row      <= pixel_q[0].row;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Output monitor: checks each result beat, drives out_stall
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin : result_monitor
		logic [CNT_W-1:0] want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (escape_q.size() == 0) begin
					$display("%0t ns: unexpected beat, expected none, got escape_count %0d",
						$time, escape_count);
					mismatches++;
				end else begin
					want = escape_q.pop_front();
					if (escape_count !== want) begin
						$display("%0t ns: escape_count expected %0d, got %0d",
							$time, want, escape_count);
						mismatches++;
					end
				end
			end
			// one long hold-off: the unit fills its result register, then stalls input
			if (hold_req && !hold_done) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				out_stall <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	// run guard
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	// call at a rising edge; returns at a rising edge
	task automatic write_reg(input logic [2:0] idx, input logic [COORD_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (reg_idx_t'(idx))
			REG_START_RE:  view_start_re  = data;
			REG_START_IM:  view_start_im  = data;
			REG_STEP_RE:   view_step_re   = data;
			REG_STEP_IM:   view_step_im   = data;
			REG_MAX_ITERS: view_max_iters = data[CNT_W-1:0];
			default: ;     // unmapped index, unit drops it
		endcase
		@(posedge clk);
	endtask

	task automatic set_view(input logic [COORD_W-1:0] sr, input logic [COORD_W-1:0] si,
			input logic [COORD_W-1:0] dr, input logic [COORD_W-1:0] di,
			input logic [CNT_W-1:0] lim);
		write_reg(REG_START_RE, sr);
		write_reg(REG_START_IM, si);
		write_reg(REG_STEP_RE, dr);
		write_reg(REG_STEP_IM, di);
		write_reg(REG_MAX_ITERS, COORD_W'(lim));
	endtask

	task automatic add_pixel(input int col, input int rw);
		pixel_t px;
		px.column = IDX_W'(col);
		px.row    = IDX_W'(rw);
		pixel_q.push_back(px);
	endtask

	// every pixel gives one result, so empty queues mean the unit is idle
	task automatic drain();
		do
			@(negedge clk);
		while (pixel_q.size() != 0 || escape_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [COORD_W-1:0] sr, si, dr, di;
		logic [CNT_W-1:0]   lim;
		int                 top_idx;
		// power-on view: -2.0 - 1.0i corner, limit 256
		view_start_re  = 32'shE000_0000;
		view_start_im  = 32'shF000_0000;
		view_step_re   = 32'sd1610612;
		view_step_im   = 32'sd1073741;
		view_max_iters = 12'd256;
		top_idx        = (1 << $bits(cfg_index)) - 1;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset view: corners, origin (inside), around -0.5, mid image
		@(negedge clk);
		add_pixel(0, 0);
		add_pixel(4095, 4095);
		add_pixel(4095, 0);
		add_pixel(0, 4095);
		add_pixel(333, 250);
		add_pixel(250, 250);
		add_pixel(400, 120);
		add_pixel(2048, 2048);
		drain();

		// zero limit: count is zero even inside the set
		write_reg(REG_MAX_ITERS, '0);
		@(negedge clk);
		add_pixel(333, 250);
		add_pixel(4095, 4095);
		drain();

		// coordinate overflow, both signs; top limit
		set_view(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1);
		@(negedge clk);
		add_pixel(4095, 4095);
		add_pixel(0, 0);
		add_pixel(1, 1);
		drain();
		set_view(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1);
		@(negedge clk);
		add_pixel(4095, 4095);
		add_pixel(1, 0);
		drain();

		// c = -2 exactly: magnitude stays at 4.0, never strictly above, runs to the limit.
		// Unmapped indices must leave the view alone.
		set_view(32'shE000_0000, '0, '0, '0, '1);
		for (int k = int'(REG_MAX_ITERS) + 1; k <= top_idx; k++)
			write_reg(3'(k), $urandom());
		@(negedge clk);
		add_pixel(0, 0);
		add_pixel(4095, 4095);
		drain();

		// random views: mostly windows over the set, small limits
		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				LONG_PHASE: lim = CNT_W'($urandom_range(150, 300));
				TINY_PHASE: lim = CNT_W'($urandom_range(0, 3));
				default:    lim = CNT_W'($urandom_range(4, 64));
			endcase
			if (p == NOISE_PHASE) begin
				sr = $urandom();
				si = $urandom();
				dr = $urandom();
				di = $urandom();
			end else begin
				sr = -32'sd671088640 + $urandom_range(0, 805306368);  // -2.5 .. 0.5
				si = -32'sd402653184 + $urandom_range(0, 536870912);  // -1.5 .. 0.5
				dr = $urandom_range(200000, 2000000);
				di = $urandom_range(200000, 2000000);
				if ($urandom_range(0, 3) == 0)
					dr = -dr;
				if ($urandom_range(0, 3) == 0)
					di = -di;
			end
			set_view(sr, si, dr, di, lim);
			if ($urandom_range(0, 2) == 0)
				write_reg(3'($urandom_range(int'(REG_MAX_ITERS) + 1, top_idx)), $urandom());

			@(negedge clk);
			steady = (p == STEADY_PHASE);
			for (int i = 0; i < RAND_ITEMS; i++) begin
				// most pixels inside a 512 window, the rest anywhere
				if ($urandom_range(0, 9) < 7)
					add_pixel($urandom_range(0, 511), $urandom_range(0, 511));
				else
					add_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
			end
			if (p == HOLD_PHASE)
				hold_req = 1'b1;
			drain();
			@(negedge clk);
			steady = 1'b0;
			@(posedge clk);
		end

		drain();
		// a few more cycles to catch a stray beat
		repeat (32) @(posedge clk);
		if (mismatches == 0 && escape_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
